@@ sv/hsc_pkg.sv @@
package hsc_pkg;

	localparam int WORD_W        = 63;
	localparam int SYN_W         = 6;
	localparam int DLEN_W        = 6;
	localparam int MAX_DATA_BITS = 57;
	localparam int DLEN_RESET    = 57;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SYN_W-1:0]  syn_t;
	typedef logic [DLEN_W-1:0] len_t;

	// decode status carried from the finishing stage to the output register
	typedef struct packed {
		logic error_fixed;
		logic syndrome_invalid;
	} flags_t;

	// bit index of the k-th data bit: the k-th position that is not a power of two
	function automatic int data_pos(input int k);
		int cnt;
		int res;
		cnt = 0;
		res = 0;
		for (int p = 1; p <= WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == k) res = p - 1;
				cnt++;
			end
		end
		return res;
	endfunction

	// positions whose number has bit i set
	function automatic word_t syn_mask(input int i);
		word_t m;
		m = '0;
		for (int p = 1; p <= WORD_W; p++) begin
			m[p-1] = ((p >> i) & 1) != 0;
		end
		return m;
	endfunction

endpackage

@@ sv/hamming_sec_codec.sv @@
// path: an input transfer is registered in stage 1, then stage 2, then the output register, and leaves from there
// throughput: one item per cycle, limited only by output stall
// stages: prepare (mask and scatter), syndrome xor trees, correct/insert parity and gather
// reset: arst_n low clears all stage valid bits and sets data_len to 57; no clearing pass
module hamming_sec_codec (
	input  logic           clk,
	input  logic           arst_n,
	// configuration write port
	input  logic           data_len_we,
	input  hsc_pkg::len_t  data_len_wdata,
	// input channel
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           op,
	input  hsc_pkg::word_t bits,
	// output channel
	output logic           out_valid,
	input  logic           out_stall,
	output hsc_pkg::word_t result_bits,
	output logic           error_fixed,
	output hsc_pkg::syn_t  syndrome,
	output logic           syndrome_invalid
);

	// configuration register; the user must write it only while the pipe is empty, the block does not enforce this
	hsc_pkg::len_t data_len_q;

	// stage valid bits
	logic valid_s1, valid_s2, valid_s3;

	// per-stage advance: a stage may load when it is empty or its contents move on
	logic adv_s1, adv_s2, adv_s3;

	// stage 1 payload
	logic           op_s1;
	hsc_pkg::word_t word_s1;
	hsc_pkg::len_t  cw_len_s1;

	// stage 2 payload
	logic           op_s2;
	hsc_pkg::word_t word_s2;
	hsc_pkg::len_t  cw_len_s2;
	hsc_pkg::syn_t  syn_s2;

	// stage 3 (output register)
	hsc_pkg::word_t  result_s3;
	hsc_pkg::syn_t   syndrome_s3;
	hsc_pkg::flags_t flags_s3;

	// combinational stage outputs
	hsc_pkg::word_t  prep_word;
	hsc_pkg::len_t   prep_len;
	hsc_pkg::syn_t   syn_c;
	hsc_pkg::word_t  fin_result;
	hsc_pkg::syn_t   fin_syndrome;
	hsc_pkg::flags_t fin_flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_len_q <= hsc_pkg::len_t'(hsc_pkg::DLEN_RESET);
		end else if (data_len_we) begin
			data_len_q <= data_len_wdata;
		end
	end

	// backpressure ripples from the output register towards the input
	assign adv_s3   = !valid_s3 || !out_stall;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// stage 1: clamp length, mask and scatter
	hsc_prep u_prep (
		.op       (op),
		.bits     (bits),
		.data_len (data_len_q),
		.word     (prep_word),
		.cw_len   (prep_len)
	);

	// stage 2: syndrome over the prepared word
	hsc_syn u_syn (
		.word (word_s1),
		.syn  (syn_c)
	);

	// stage 3: correct or insert parity, then gather
	hsc_finish u_finish (
		.op          (op_s2),
		.word        (word_s2),
		.syn         (syn_s2),
		.cw_len      (cw_len_s2),
		.result_bits (fin_result),
		.syndrome    (fin_syndrome),
		.flags       (fin_flags)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// payload registers, loaded only on a transfer into the stage
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1     <= op;
			word_s1   <= prep_word;
			cw_len_s1 <= prep_len;
		end
		if (adv_s2 && valid_s1) begin
			op_s2     <= op_s1;
			word_s2   <= word_s1;
			cw_len_s2 <= cw_len_s1;
			syn_s2    <= syn_c;
		end
		if (adv_s3 && valid_s2) begin
			result_s3   <= fin_result;
			syndrome_s3 <= fin_syndrome;
			flags_s3    <= fin_flags;
		end
	end

	assign out_valid        = valid_s3;
	assign result_bits      = result_s3;
	assign syndrome         = syndrome_s3;
	assign error_fixed      = flags_s3.error_fixed;
	assign syndrome_invalid = flags_s3.syndrome_invalid;

endmodule

@@ sv/hsc_prep.sv @@
module hsc_prep (
	input  logic          op,
	input  hsc_pkg::word_t bits,
	input  hsc_pkg::len_t  data_len,
	output hsc_pkg::word_t word,
	output hsc_pkg::len_t  cw_len
);

	hsc_pkg::len_t  d;
	logic [2:0]     r;
	hsc_pkg::word_t enc;
	hsc_pkg::word_t dec;

	// clamp to the supported data length
	always_comb begin
		if (data_len == '0) begin
			d = hsc_pkg::len_t'(1);
		end else if (data_len > hsc_pkg::len_t'(hsc_pkg::MAX_DATA_BITS)) begin
			d = hsc_pkg::len_t'(hsc_pkg::MAX_DATA_BITS);
		end else begin
			d = data_len;
		end
	end

	// least r with 2^r >= r + d + 1
	always_comb begin
		if (d <= hsc_pkg::len_t'(1)) begin
			r = 3'd2;
		end else if (d <= hsc_pkg::len_t'(4)) begin
			r = 3'd3;
		end else if (d <= hsc_pkg::len_t'(11)) begin
			r = 3'd4;
		end else if (d <= hsc_pkg::len_t'(26)) begin
			r = 3'd5;
		end else begin
			r = 3'd6;
		end
	end

	assign cw_len = d + hsc_pkg::len_t'(r);

	// scatter data bits to their positions, parity slots left clear
	always_comb begin
		enc = '0;
		for (int k = 0; k < hsc_pkg::MAX_DATA_BITS; k++) begin
			enc[hsc_pkg::data_pos(k)] = bits[k] && (hsc_pkg::len_t'(k) < d);
		end
	end

	// drop codeword bits beyond the codeword length
	always_comb begin
		for (int i = 0; i < hsc_pkg::WORD_W; i++) begin
			dec[i] = bits[i] && (hsc_pkg::len_t'(i) < cw_len);
		end
	end

	assign word = (op == hsc_pkg::OP_DECODE) ? dec : enc;

endmodule

@@ sv/hsc_syn.sv @@
module hsc_syn (
	input  hsc_pkg::word_t word,
	output hsc_pkg::syn_t  syn
);

	// each syndrome bit is the parity over its check group
	always_comb begin
		for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
			syn[i] = ^(word & hsc_pkg::syn_mask(i));
		end
	end

endmodule

@@ sv/hsc_finish.sv @@
module hsc_finish (
	input  logic           op,
	input  hsc_pkg::word_t word,
	input  hsc_pkg::syn_t  syn,
	input  hsc_pkg::len_t  cw_len,
	output hsc_pkg::word_t result_bits,
	output hsc_pkg::syn_t  syndrome,
	output hsc_pkg::flags_t flags
);

	logic           fix;
	logic           bad;
	hsc_pkg::word_t cw;
	hsc_pkg::word_t enc;
	hsc_pkg::word_t dec;

	assign fix = (syn != '0) && (syn <= cw_len);
	assign bad = (syn > cw_len);

	// flip the named position
	always_comb begin
		for (int i = 0; i < hsc_pkg::WORD_W; i++) begin
			cw[i] = word[i] ^ (fix && (syn == hsc_pkg::syn_t'(i + 1)));
		end
	end

	// parity bits go into the power-of-two slots
	always_comb begin
		enc = word;
		for (int i = 0; i < hsc_pkg::SYN_W; i++) begin
			enc[(1 << i) - 1] = syn[i];
		end
	end

	// gather data bits back into a packed word
	always_comb begin
		dec = '0;
		for (int k = 0; k < hsc_pkg::MAX_DATA_BITS; k++) begin
			dec[k] = cw[hsc_pkg::data_pos(k)];
		end
	end

	always_comb begin
		if (op == hsc_pkg::OP_DECODE) begin
			result_bits            = dec;
			syndrome               = syn;
			flags.error_fixed      = fix;
			flags.syndrome_invalid = bad;
		end else begin
			result_bits            = enc;
			syndrome               = '0;
			flags.error_fixed      = 1'b0;
			flags.syndrome_invalid = 1'b0;
		end
	end

endmodule

@@ sv/hsc_checker.sv @@
module hsc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input hsc_pkg::word_t result_bits,
	input logic           error_fixed,
	input hsc_pkg::syn_t  syndrome,
	input logic           syndrome_invalid
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_bits) && $stable(syndrome))
		else $error("stalled result changed");

	// a flag needs a non-zero syndrome, and the two flags exclude each other
	a_flags_need_syn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_fixed || syndrome_invalid) |->
			syndrome != '0 && !(error_fixed && syndrome_invalid))
		else $error("flag without syndrome");

	// a non-zero syndrome is either corrected or flagged
	a_syn_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && syndrome != '0 |-> error_fixed || syndrome_invalid)
		else $error("syndrome neither fixed nor flagged");

	// with no output stall an accepted transfer passes stage 1, stage 2 and the output register and shows out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind hamming_sec_codec hsc_checker u_hsc_checker (.*);

@@ verif/tb_hamming_sec_codec.sv @@
`timescale 1ns / 1ps

module tb_hamming_sec_codec;

	localparam int CLK_PERIOD      = 10;
	localparam int LIMIT_CYCLES    = 1_000_000;
	localparam int NUM_ROWS        = 23;
	localparam int NUM_PHASES      = 14;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int SETTLE_CYCLES   = 6;

	localparam logic ENC = hsc_pkg::OP_ENCODE;
	localparam logic DEC = hsc_pkg::OP_DECODE;

	localparam hsc_pkg::word_t ALL_ONES  = 63'h7fff_ffff_ffff_ffff;
	localparam hsc_pkg::word_t DATA57_1S = 63'h01ff_ffff_ffff_ffff;

	// one codec result as it appears on the output port
	typedef struct packed {
		hsc_pkg::word_t bits;
		logic           fixed;
		hsc_pkg::syn_t  syn;
		logic           bad;
	} codec_out_t;

	// directed vector: data_len to apply, the transfer, and an optional hand-written answer
	typedef struct packed {
		hsc_pkg::len_t  dlen;
		logic           op;
		hsc_pkg::word_t bits;
		logic           known;
		codec_out_t     want;
	} dir_row_t;

	logic           clk            = 1'b0;
	logic           arst_n         = 1'b0;
	logic           data_len_we    = 1'b0;
	hsc_pkg::len_t  data_len_wdata = '0;
	logic           in_valid       = 1'b0;
	logic           in_stall;
	logic           op             = ENC;
	hsc_pkg::word_t bits           = '0;
	logic           out_valid;
	logic           out_stall      = 1'b0;
	hsc_pkg::word_t result_bits;
	logic           error_fixed;
	hsc_pkg::syn_t  syndrome;
	logic           syndrome_invalid;

	// hand-written answer travelling with the transfer currently offered
	logic           row_known      = 1'b0;
	codec_out_t     row_want       = '0;

	// testbench copy of the data_len register
	hsc_pkg::len_t  model_len      = hsc_pkg::len_t'(hsc_pkg::DLEN_RESET);

	codec_out_t outputs_due[$];
	dir_row_t   dir_rows[NUM_ROWS];

	int         err_count      = 0;
	int         items_sent     = 0;
	int         results_seen   = 0;
	int         fixes_seen     = 0;
	int         invalid_seen   = 0;
	int         len_writes     = 0;
	int         cycle_count    = 0;
	int         stall_run      = 0;
	int         stall_pick     = 0;
	bit         calm           = 1'b0;

	hamming_sec_codec dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_len_we      (data_len_we),
		.data_len_wdata   (data_len_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.op               (op),
		.bits             (bits),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_bits      (result_bits),
		.error_fixed      (error_fixed),
		.syndrome         (syndrome),
		.syndrome_invalid (syndrome_invalid)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// data bits in use, with zero and oversize register values clamped
	function automatic int used_bits(input hsc_pkg::len_t len);
		int d;
		d = int'(len);
		if (d < 1) d = 1;
		if (d > hsc_pkg::MAX_DATA_BITS) d = hsc_pkg::MAX_DATA_BITS;
		return d;
	endfunction

	// codeword length: data bits plus the least parity count that covers them
	function automatic int cw_length(input hsc_pkg::len_t len);
		int d;
		int r;
		d = used_bits(len);
		r = 0;
		while ((1 << r) < r + d + 1) r++;
		return d + r;
	endfunction

	function automatic codec_out_t hamming_predict(input hsc_pkg::len_t len, input logic op_i,
		input hsc_pkg::word_t w);
		codec_out_t     o;
		hsc_pkg::word_t cw;
		int             n;
		int             k;
		int             s;
		int             p;
		o = '0;
		cw = '0;
		n = cw_length(len);
		k = 0;
		s = 0;
		if (op_i == hsc_pkg::OP_ENCODE) begin
			// scatter data onto non-power-of-two positions
			for (p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					o.bits[p-1] = w[k];
					k++;
				end
			end
			for (p = 1; p <= n; p++) begin
				if (o.bits[p-1]) s ^= p;
			end
			// each parity position takes the matching syndrome bit to make its group even
			for (p = 1; p <= n; p++) begin
				if ((p & (p - 1)) == 0 && (s & p) != 0) o.bits[p-1] = 1'b1;
			end
		end else begin
			for (p = 1; p <= n; p++) begin
				cw[p-1] = w[p-1];
				if (w[p-1]) s ^= p;
			end
			if (s != 0) begin
				if (s <= n) begin
					cw[s-1] = ~cw[s-1];
					o.fixed = 1'b1;
				end else begin
					o.bad = 1'b1;
				end
			end
			o.syn = hsc_pkg::syn_t'(s);
			for (p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					o.bits[k] = cw[p-1];
					k++;
				end
			end
		end
		return o;
	endfunction

	function automatic hsc_pkg::word_t rnd_word();
		return hsc_pkg::word_t'({$urandom(), $urandom()});
	endfunction

	// mostly dense random words, now and then the extremes or a sparse pattern
	function automatic hsc_pkg::word_t make_word();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return ALL_ONES;
			2: return rnd_word() & rnd_word() & rnd_word();
			default: return rnd_word();
		endcase
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int sel;
		if (calm) return 0;
		sel = $urandom_range(0, 99);
		if (sel < 45) return 0;
		if (sel < 85) return $urandom_range(1, 3);
		if (sel < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		err_count++;
		$display("[%0t] mismatch on %s: got %h, want %h (result %0d)",
			$realtime, what, got, want, results_seen);
	endtask

	// ---------------------------------------------------------------------------
	// receive side: random stall pattern, with calm phases where it never stalls
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
		end else if (calm || out_stall) begin
			out_stall <= 1'b0;
			stall_run = calm ? 0 : $urandom_range(0, 12);
		end else begin
			stall_pick = pick_gap();
			if (stall_pick == 0) begin
				stall_run = $urandom_range(0, 6);
			end else begin
				out_stall <= 1'b1;
				stall_run = stall_pick - 1;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// scoreboard: predict on each input transfer, compare on each output transfer
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		codec_out_t want;
		if (arst_n) begin
			// hand-written answers win over the predictor for the directed rows that carry one
			if (in_valid && !in_stall)
				outputs_due.push_back(row_known ? row_want : hamming_predict(model_len, op, bits));
			if (out_valid && !out_stall) begin
				if (outputs_due.size() == 0) begin
					report_mismatch("unexpected result", 64'(result_bits), 64'd0);
				end else begin
					want = outputs_due.pop_front();
					if (result_bits !== want.bits)
						report_mismatch("result_bits", 64'(result_bits), 64'(want.bits));
					if (error_fixed !== want.fixed)
						report_mismatch("error_fixed", 64'(error_fixed), 64'(want.fixed));
					if (syndrome !== want.syn)
						report_mismatch("syndrome", 64'(syndrome), 64'(want.syn));
					if (syndrome_invalid !== want.bad)
						report_mismatch("syndrome_invalid", 64'(syndrome_invalid),
							64'(want.bad));
					if (want.fixed) fixes_seen++;
					if (want.bad) invalid_seen++;
				end
				results_seen++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, outputs_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// offer one transfer after a random gap and hold it until it is taken
	task automatic send_item(input logic op_i, input hsc_pkg::word_t w, input logic known,
		input codec_out_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= op_i;
		bits      <= w;
		row_known <= known;
		row_want  <= want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// hold off the sender until every predicted result has come back
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outputs_due.size() != 0) @(posedge clk);
	endtask

	// register writes only happen with the pipeline empty
	task automatic set_len(input hsc_pkg::len_t v);
		drain_outputs();
		data_len_we    <= 1'b1;
		data_len_wdata <= v;
		@(posedge clk);
		data_len_we    <= 1'b0;
		model_len = v;
		len_writes++;
	endtask

	// ---------------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------------
	initial begin
		int             phase_len[NUM_PHASES];
		int             sel;
		int             n_cur;
		int             flip;
		hsc_pkg::word_t cw;
		hsc_pkg::word_t upper;
		codec_out_t     enc;

		// directed rows: zero, all-ones and single-bit words at the widest setting, clamped
		// register values, upper bits beyond the codeword, and syndromes past its end
		dir_rows = '{
			'{6'd57, ENC, 63'h0,                  1'b1, '{63'h0, 1'b0, 6'd0, 1'b0}},
			'{6'd57, DEC, 63'h0,                  1'b1, '{63'h0, 1'b0, 6'd0, 1'b0}},
			'{6'd57, ENC, ALL_ONES,               1'b1, '{ALL_ONES, 1'b0, 6'd0, 1'b0}},
			'{6'd57, DEC, ALL_ONES,               1'b1, '{DATA57_1S, 1'b0, 6'd0, 1'b0}},
			'{6'd57, DEC, 63'h1,                  1'b1, '{63'h0, 1'b1, 6'd1, 1'b0}},
			'{6'd57, DEC, 63'h4,                  1'b1, '{63'h0, 1'b1, 6'd3, 1'b0}},
			'{6'd57, DEC, 63'h4000_0000_0000_0000, 1'b1, '{63'h0, 1'b1, 6'd63, 1'b0}},
			'{6'd57, ENC, 63'h1,                  1'b0, '0},
			'{6'd57, ENC, 63'h0155_5555_5555_5555, 1'b0, '0},
			'{6'd57, DEC, 63'h2aaa_aaaa_aaaa_aaaa, 1'b0, '0},
			'{6'd57, DEC, 63'h60,                 1'b0, '0},
			'{6'd0,  ENC, ALL_ONES,               1'b1, '{63'h7, 1'b0, 6'd0, 1'b0}},
			'{6'd0,  DEC, ALL_ONES,               1'b1, '{63'h1, 1'b0, 6'd0, 1'b0}},
			'{6'd0,  DEC, 63'h2,                  1'b1, '{63'h0, 1'b1, 6'd2, 1'b0}},
			'{6'd2,  DEC, 63'hc,                  1'b1, '{63'h1, 1'b0, 6'd7, 1'b1}},
			'{6'd2,  DEC, 63'h18,                 1'b0, '0},
			'{6'd2,  DEC, 63'h1c,                 1'b0, '0},
			'{6'd2,  ENC, 63'h3,                  1'b0, '0},
			'{6'd63, ENC, 63'h0123_4567_89ab_cdef, 1'b0, '0},
			'{6'd63, DEC, ALL_ONES,               1'b1, '{DATA57_1S, 1'b0, 6'd0, 1'b0}},
			'{6'd58, DEC, 63'h5,                  1'b0, '0},
			'{6'd5,  DEC, 63'h300,                1'b0, '0},
			'{6'd5,  DEC, 63'hc0,                 1'b1, '{63'h8, 1'b0, 6'd15, 1'b1}}
		};
		// -1 picks a random register value for that phase
		phase_len = '{57, 1, 2, 3, 4, 5, 11, 26, 32, 0, 63, 58, -1, -1};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, data_len rewritten whenever a row asks for a new one
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (dir_rows[i].dlen != model_len) set_len(dir_rows[i].dlen);
			send_item(dir_rows[i].op, dir_rows[i].bits, dir_rows[i].known, dir_rows[i].want);
		end

		// random phases, one data_len setting each; every fourth phase runs without idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_len(phase_len[ph] < 0 ? hsc_pkg::len_t'($urandom_range(0, 63)) :
				hsc_pkg::len_t'(phase_len[ph]));
			calm = (ph % 4 == 3);
			n_cur = cw_length(model_len);
			for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
				// occasional full hold-off of the sender
				if ($urandom_range(0, 99) == 0) drain_outputs();
				sel = $urandom_range(0, 99);
				if (sel < 30) begin
					send_item(ENC, make_word(), 1'b0, '0);
				end else if (sel < 80) begin
					// well-formed codeword, mostly with one flipped bit inside it
					enc = hamming_predict(model_len, ENC, make_word());
					cw = enc.bits;
					if ($urandom_range(0, 9) < 6) begin
						flip = $urandom_range(0, n_cur - 1);
						cw[flip] = ~cw[flip];
					end
					// junk above the codeword, which the decoder must ignore
					if ($urandom_range(0, 3) == 0 && n_cur < hsc_pkg::WORD_W) begin
						upper = ~((hsc_pkg::word_t'(1) << n_cur) - hsc_pkg::word_t'(1));
						cw = cw | (rnd_word() & upper);
					end
					send_item(DEC, cw, 1'b0, '0);
				end else begin
					// noise: arbitrary words, often with two or more bits wrong
					send_item(DEC, make_word(), 1'b0, '0);
				end
			end
		end

		calm = 1'b0;
		drain_outputs();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (outputs_due.size() != 0)
			report_mismatch("results never returned", 64'(outputs_due.size()), 64'd0);

		$display("%0d transfers in, %0d results compared across %0d data_len writes",
			items_sent, results_seen, len_writes);
		$display("%0d single-bit corrections, %0d syndromes beyond the codeword, %0d mismatches",
			fixes_seen, invalid_seen, err_count);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
